@@ design/fdvs_pkg.sv @@
package fdvs_pkg;

  // Sensor geometry and derived sizes.
  localparam int SENSOR_WIDTH  = 304;
  localparam int SENSOR_HEIGHT = 240;
  localparam int PIXELS        = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int IDX_W         = $clog2(PIXELS);

  // Front pipeline: six arithmetic stages, one per cube-root bit, one final stage.
  localparam int CUBE_BITS = 21;
  localparam int FRONT_LAT = 6 + CUBE_BITS + 1;

  // Queue between front and back.
  localparam int QDEPTH = 32;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD      = 2'd0;
  localparam logic [1:0] CFG_FRAME_DURATION = 2'd1;
  localparam logic [1:0] CFG_REFRACTORY     = 2'd2;

  typedef struct packed {
    logic [8:0]  column;
    logic [7:0]  row;
    logic [23:0] frame_number;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_t;

  typedef struct packed {
    logic [8:0]  event_x;
    logic [7:0]  event_y;
    logic [43:0] event_time;
    logic        polarity;
  } event_t;

  typedef struct packed {
    logic [15:0] threshold_q12;
    logic [19:0] frame_duration_us;
    logic [23:0] refractory_us;
  } cfg_t;

  typedef struct packed {
    logic             on_sensor;
    logic [IDX_W-1:0] idx;
    logic [8:0]       x;
    logic [7:0]       y;
    logic [43:0]      stamp;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [14:0] level;
  } work_t;

  typedef struct packed {
    logic [14:0] level;
    logic [43:0] quiet_until;
  } pix_state_t;

  // Status the back end and queue report to the front for admission.
  typedef struct packed {
    logic            clearing;
    logic [QPTR_W:0] q_count;
  } flow_t;

  typedef logic [24:0] lin_tab_t [0:255];

  // floor(r^5 / 2^16) for r below 2^16.
  function automatic logic [63:0] fifth_down16(input logic [63:0] r);
    logic [63:0] p;
    logic [63:0] hi;
    logic [63:0] lo;
    p  = r * r;
    p  = p * p;
    hi = p >> 32;
    lo = p & 64'hFFFF_FFFF;
    return ((hi * r) << 16) + ((lo * r) >> 16);
  endfunction

  // sRGB code to linear light, Q1.24, built at elaboration.
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t    tab;
    logic [63:0] v;
    logic [63:0] t;
    logic [63:0] sq;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    for (int i = 0; i < 256; i++) begin
      v = 64'(i);
      if (i <= 10) begin
        tab[i] = 25'((v * 64'd100 * 64'd16777216 + 64'd164730) / 64'd329460);
      end else if (i == 255) begin
        tab[i] = 25'd16777216;
      end else begin
        t  = ((64'd1000 * v + 64'd14025) * 64'd65536 + 64'd134512) / 64'd269025;
        sq = t * t;
        lo = 64'd0;
        hi = 64'd65535;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (fifth_down16(mid) <= (sq << 32)) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        tab[i] = 25'((sq * lo + (64'd1 << 23)) >> 24);
      end
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

@@ design/fdvs_front.sv @@
module fdvs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fdvs_pkg::pixel_t     in_pixel,
  input  logic [19:0]          frame_duration_us,
  input  fdvs_pkg::flow_t      flow,
  output logic                 push_valid,
  output fdvs_pkg::work_t      push_item
);

  localparam int LAT = fdvs_pkg::FRONT_LAT;
  localparam int NB  = fdvs_pkg::CUBE_BITS;

  logic                accept;
  logic [5:0]          inflight_r, inflight_nxt;
  logic                v_r [0:LAT-1];
  fdvs_pkg::meta_t     meta_r [0:LAT-1];
  fdvs_pkg::meta_t     meta_in;

  logic [24:0] lin_r_r, lin_g_r, lin_b_r;
  logic [40:0] pr_r, pg_r, pb_r;
  logic [24:0] y2_r, y3_r, y4_r, y5_r;
  logic [39:0] prod3;
  logic        small3_r, small4_r, small5_r;
  logic [31:0] n3_r;
  logic [15:0] m4_r;
  logic [11:0] q4_r;
  logic [15:0] rem5;
  logic [11:0] llin5_r;

  logic [20:0] cb_c_r   [1:NB];
  logic [63:0] cb_c3_r  [1:NB];
  logic [43:0] cb_t1_r  [1:NB];
  logic [22:0] cb_t2_r  [1:NB];
  logic [24:0] cb_y_r   [1:NB];
  logic        cb_sm_r  [1:NB];
  logic [11:0] cb_ll_r  [1:NB];

  logic [15:0] lcube;
  logic [14:0] level_r;

  // Admission: items in flight plus queued never exceed the queue depth.
  assign accept   = in_valid && in_ready;
  assign in_ready = !flow.clearing &&
                    ((7'(inflight_r) + 7'(flow.q_count)) < 7'(fdvs_pkg::QDEPTH));

  always_comb begin
    inflight_nxt = inflight_r + 6'(accept) - 6'(v_r[LAT-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // Classify the pixel and compute its address, flipped row and timestamp.
  always_comb begin
    meta_in.on_sensor = (in_pixel.column < 9'(fdvs_pkg::SENSOR_WIDTH)) &&
                        (in_pixel.row < 8'(fdvs_pkg::SENSOR_HEIGHT));
    meta_in.idx    = fdvs_pkg::IDX_W'(32'(in_pixel.row) * fdvs_pkg::SENSOR_WIDTH
                                      + 32'(in_pixel.column));
    meta_in.x      = in_pixel.column;
    meta_in.y      = 8'(fdvs_pkg::SENSOR_HEIGHT - 1) - in_pixel.row;
    meta_in.stamp  = 44'(in_pixel.frame_number) * 44'(frame_duration_us);
  end

  // Valid bits travel with the item through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      v_r[0] <= accept;
      for (int i = 1; i < LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= meta_in;
    for (int i = 1; i < LAT; i++) begin
      meta_r[i] <= meta_r[i-1];
    end
  end

  // Linearize, weight and sum the channels, then the linear L* branch.
  assign prod3 = 40'(y2_r) * 40'd24389;
  assign rem5  = m4_r - 16'(q4_r) * 16'd27;

  always_ff @(posedge clk) begin
    lin_r_r  <= fdvs_pkg::LIN_TAB[in_pixel.red];
    lin_g_r  <= fdvs_pkg::LIN_TAB[in_pixel.green];
    lin_b_r  <= fdvs_pkg::LIN_TAB[in_pixel.blue];
    pr_r     <= 41'(lin_r_r) * 41'd13938;
    pg_r     <= 41'(lin_g_r) * 41'd46868;
    pb_r     <= 41'(lin_b_r) * 41'd4730;
    y2_r     <= 25'((pr_r + pg_r + pb_r + 41'd32768) >> 16);
    y3_r     <= y2_r;
    small3_r <= prod3 <= (40'd216 << 24);
    n3_r     <= 32'(prod3 + 40'd884736);
    y4_r     <= y3_r;
    small4_r <= small3_r;
    m4_r     <= n3_r[31:16];
    q4_r     <= 12'((28'(n3_r[31:16]) * 28'd2427) >> 16);
    y5_r     <= y4_r;
    small5_r <= small4_r;
    llin5_r  <= (rem5 >= 16'd27) ? q4_r + 12'd1 : q4_r;
  end

  // Cube root of Y * 2^36, one result bit per stage, tracking c^3, 3c^2 and 3c.
  for (genvar k = 0; k < NB; k++) begin : g_cube
    localparam int B = NB - 1 - k;
    logic [20:0] c_in;
    logic [63:0] c3_in;
    logic [43:0] t1_in;
    logic [22:0] t2_in;
    logic [24:0] y_in;
    logic        sm_in;
    logic [11:0] ll_in;
    logic [63:0] cand3;
    logic [63:0] target;
    logic        fits;

    if (k == 0) begin : g_first
      assign c_in  = '0;
      assign c3_in = '0;
      assign t1_in = '0;
      assign t2_in = '0;
      assign y_in  = y5_r;
      assign sm_in = small5_r;
      assign ll_in = llin5_r;
    end else begin : g_next
      assign c_in  = cb_c_r[k];
      assign c3_in = cb_c3_r[k];
      assign t1_in = cb_t1_r[k];
      assign t2_in = cb_t2_r[k];
      assign y_in  = cb_y_r[k];
      assign sm_in = cb_sm_r[k];
      assign ll_in = cb_ll_r[k];
    end

    assign target = {3'b000, y_in, 36'd0};
    assign cand3  = c3_in + (64'(t1_in) << B) + (64'(t2_in) << (2 * B))
                    + (64'd1 << (3 * B));
    assign fits   = cand3 <= target;

    always_ff @(posedge clk) begin
      if (fits) begin
        cb_c_r[k+1]  <= c_in | (21'd1 << B);
        cb_c3_r[k+1] <= cand3;
        cb_t1_r[k+1] <= 44'(64'(t1_in) + (64'(t2_in) << (B + 1)) + (64'd3 << (2 * B)));
        cb_t2_r[k+1] <= t2_in + (23'd3 << B);
      end else begin
        cb_c_r[k+1]  <= c_in;
        cb_c3_r[k+1] <= c3_in;
        cb_t1_r[k+1] <= t1_in;
        cb_t2_r[k+1] <= t2_in;
      end
      cb_y_r[k+1]  <= y_in;
      cb_sm_r[k+1] <= sm_in;
      cb_ll_r[k+1] <= ll_in;
    end
  end

  // Final L*: pick the linear branch for dark pixels, else 116*cbrt - 16.
  assign lcube = 16'((28'(cb_c_r[NB]) * 28'd116 + 28'd2048) >> 12) - 16'd4096;

  always_ff @(posedge clk) begin
    level_r <= cb_sm_r[NB] ? 15'(cb_ll_r[NB]) : lcube[14:0];
  end

  assign push_valid      = v_r[LAT-1];
  assign push_item.meta  = meta_r[LAT-1];
  assign push_item.level = level_r;

endmodule

@@ design/fdvs_queue.sv @@
module fdvs_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push_valid,
  input  fdvs_pkg::work_t              push_item,
  input  logic                         pop,
  output fdvs_pkg::work_t              head,
  output logic [fdvs_pkg::QPTR_W:0]    count
);

  fdvs_pkg::work_t                q_r [0:fdvs_pkg::QDEPTH-1];
  logic [fdvs_pkg::QPTR_W-1:0]    wr_r, wr_nxt;
  logic [fdvs_pkg::QPTR_W-1:0]    rd_r, rd_nxt;
  logic [fdvs_pkg::QPTR_W:0]      cnt_r, cnt_nxt;

  // Pointer and count update; the front never pushes into a full queue.
  always_comb begin
    wr_nxt  = wr_r + fdvs_pkg::QPTR_W'(push_valid);
    rd_nxt  = rd_r + fdvs_pkg::QPTR_W'(pop);
    cnt_nxt = cnt_r + (fdvs_pkg::QPTR_W + 1)'(push_valid) - (fdvs_pkg::QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      q_r[wr_r] <= push_item;
    end
  end

  assign head  = q_r[rd_r];
  assign count = cnt_r;

endmodule

@@ design/fdvs_back.sv @@
module fdvs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fdvs_pkg::work_t              q_head,
  input  logic [fdvs_pkg::QPTR_W:0]    q_count,
  output logic                         pop,
  output logic                         clearing,
  input  logic [15:0]                  threshold_q12,
  input  logic [23:0]                  refractory_us,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fdvs_pkg::event_t             out_event
);

  localparam int IW = fdvs_pkg::IDX_W;

  fdvs_pkg::pix_state_t mem [0:fdvs_pkg::PIXELS-1];

  logic                 clr_r;
  logic [IW-1:0]        clr_addr_r;
  logic                 b_v_r;
  fdvs_pkg::work_t      b_item_r;
  fdvs_pkg::pix_state_t rd_r;
  logic                 fwd_hit_r;
  fdvs_pkg::pix_state_t fwd_r;

  fdvs_pkg::pix_state_t stored;
  fdvs_pkg::pix_state_t new_state;
  logic                 quiet;
  logic [32:0]          lvl_scaled;
  logic [32:0]          on_bound;
  logic [32:0]          off_bound;
  logic                 on_ev;
  logic                 off_ev;
  logic                 fire;
  logic [44:0]          deadline;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  fdvs_pkg::pix_state_t mem_wdata;

  fdvs_pkg::event_t     ofifo_r [0:3];
  logic [1:0]           owr_r;
  logic [1:0]           ord_r;
  logic [2:0]           ocnt_r, ocnt_nxt;
  logic                 opop;
  fdvs_pkg::event_t     ev;

  // Take an item only when the output buffer can absorb everything in flight.
  assign clearing = clr_r;
  assign pop      = !clr_r && (q_count != '0) && ((4'(ocnt_r) + 4'(b_v_r)) <= 4'd3);

  // Clearing pass over the pixel store after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + IW'(1);
      if (clr_addr_r == IW'(fdvs_pkg::PIXELS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Event decision on the stored state, with the previous write forwarded.
  always_comb begin
    stored     = fwd_hit_r ? fwd_r : rd_r;
    quiet      = b_item_r.meta.stamp < stored.quiet_until;
    lvl_scaled = {6'd0, b_item_r.level, 12'd0};
    on_bound   = 33'(stored.level) * 33'(17'd4096 + 17'(threshold_q12));
    off_bound  = 33'(stored.level) * 33'(13'd4096 - {1'b0, threshold_q12[11:0]});
    on_ev      = lvl_scaled > on_bound;
    off_ev     = (threshold_q12 < 16'd4096) && (lvl_scaled < off_bound);
    fire       = b_v_r && b_item_r.meta.on_sensor && !quiet && (on_ev || off_ev);
    deadline   = 45'(b_item_r.meta.stamp) + 45'(refractory_us);
    new_state.level       = b_item_r.level;
    new_state.quiet_until = deadline[44] ? '1 : deadline[43:0];
  end

  // Single write port shared by the clearing pass and event updates.
  always_comb begin
    mem_we    = clr_r || fire;
    mem_waddr = clr_r ? clr_addr_r : b_item_r.meta.idx;
    mem_wdata = clr_r ? '0 : new_state;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_r <= mem[q_head.meta.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r     <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      b_v_r     <= pop;
      fwd_hit_r <= fire && (b_item_r.meta.idx == q_head.meta.idx);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item_r <= q_head;
    end
    fwd_r <= new_state;
  end

  // Output buffer of four beats.
  always_comb begin
    ev.event_x    = b_item_r.meta.x;
    ev.event_y    = b_item_r.meta.y;
    ev.event_time = b_item_r.meta.stamp;
    ev.polarity   = on_ev;
    opop          = out_valid && out_ready;
    ocnt_nxt      = ocnt_r + 3'(fire) - 3'(opop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owr_r  <= owr_r + 2'(fire);
      ord_r  <= ord_r + 2'(opop);
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ofifo_r[owr_r] <= ev;
    end
  end

  assign out_valid = ocnt_r != 3'd0;
  assign out_event = ofifo_r[ord_r];

endmodule

@@ design/frame_to_dvs_event_emulator_unit.sv @@
// Frame-to-event-camera emulator.
// Input channel (in_valid/in_ready/in_pixel): one sRGB pixel per beat with its
// column, row and frame number, in any order. Output channel
// (out_valid/out_ready/out_event): zero or one event per pixel, in input order.
// Configuration (cfg_we/cfg_index/cfg_data): contrast threshold, frame duration
// and refractory time; write only while the block is idle.
// Throughput: one pixel per cycle while in_ready is high. An accepted pixel
// passes 28 lightness stages (linearization table, weighted sum, one cube-root
// bit per stage, the first loading at the accepting edge), the queue, the
// pixel-store read, then the event decision, which writes the store and the
// output buffer, from which the event is presented.
// After reset the pixel store is cleared one entry a cycle, 72960 entries, and
// in_ready stays low until the pass is done. When the receiver stalls, events
// collect in a four-beat output buffer, the back end stops taking work and the
// 32-entry queue fills; in_ready falls when queued plus in-flight pixels reach
// the queue depth.
module frame_to_dvs_event_emulator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fdvs_pkg::pixel_t   in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output fdvs_pkg::event_t   out_event,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  fdvs_pkg::cfg_t                 cfg_r;
  fdvs_pkg::flow_t                flow;
  logic                           push_valid;
  fdvs_pkg::work_t                push_item;
  logic                           pop;
  fdvs_pkg::work_t                q_head;
  logic [fdvs_pkg::QPTR_W:0]      q_count;
  logic                           clearing;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_q12     <= 16'd410;
      cfg_r.frame_duration_us <= 20'd1000;
      cfg_r.refractory_us     <= 24'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        fdvs_pkg::CFG_THRESHOLD:      cfg_r.threshold_q12     <= cfg_data[15:0];
        fdvs_pkg::CFG_FRAME_DURATION: cfg_r.frame_duration_us <= cfg_data[19:0];
        fdvs_pkg::CFG_REFRACTORY:     cfg_r.refractory_us     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign flow.clearing = clearing;
  assign flow.q_count  = q_count;

  fdvs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel          (in_pixel),
    .frame_duration_us (cfg_r.frame_duration_us),
    .flow              (flow),
    .push_valid        (push_valid),
    .push_item         (push_item)
  );

  fdvs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head       (q_head),
    .count      (q_count)
  );

  fdvs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_count       (q_count),
    .pop           (pop),
    .clearing      (clearing),
    .threshold_q12 (cfg_r.threshold_q12),
    .refractory_us (cfg_r.refractory_us),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event     (out_event)
  );

endmodule

@@ design/fdvs_checker.sv @@
module fdvs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input fdvs_pkg::event_t out_event
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event))
    else $error("output beat changed while stalled");

  // Events only ever name pixels on the sensor.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event.event_x < 9'd304) && (out_event.event_y < 8'd240))
    else $error("event coordinates off the sensor");

  // The store is being cleared right after reset, so no pixel is taken.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("pixel accepted during store clearing");

  // Reset empties the output buffer.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event presented right after reset");

endmodule

bind frame_to_dvs_event_emulator_unit fdvs_checker u_fdvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_event (out_event)
);

@@ bench/frame_to_dvs_event_emulator_unit_tb.sv @@
`timescale 1ns / 1ps

module frame_to_dvs_event_emulator_unit_tb;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 120;
  localparam logic [43:0] TIME_MAX = 44'hFFF_FFFF_FFFF;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fdvs_pkg::pixel_t   in_pixel = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fdvs_pkg::event_t   out_event;
  logic     cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  frame_to_dvs_event_emulator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_event(out_event),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow of the registers and of the per-pixel store.
  logic [15:0] thr_q12;
  logic [19:0] frame_us;
  logic [23:0] dead_us;
  logic [14:0] level_mem [0:fdvs_pkg::PIXELS-1];
  logic [43:0] quiet_mem [0:fdvs_pkg::PIXELS-1];
  logic [24:0] lin_lut [0:255];

  fdvs_pkg::event_t event_q [$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     stall_left = 0;
  bit     timed_out = 0;

  // Directed rows; has_exp marks rows whose event is typed in.
  typedef struct {
    fdvs_pkg::pixel_t pix;
    bit               has_exp;
    bit               fires;
    fdvs_pkg::event_t ev;
  } dir_row_t;
  dir_row_t dir_rows [$];

  function automatic logic [63:0] pow5_shift16(input logic [63:0] r);
    logic [63:0] p;
    p = r * r;
    p = p * p;
    return (((p >> 32) * r) << 16) + (((p & 64'hFFFF_FFFF) * r) >> 16);
  endfunction

  function automatic logic [24:0] srgb_to_linear(input int code);
    logic [63:0] v, t, sq, lo, hi, mid;
    v = 64'(code);
    if (code <= 10) return 25'((v * 64'd100 * 64'd16777216 + 64'd164730) / 64'd329460);
    if (code == 255) return 25'd16777216;
    t  = ((64'd1000 * v + 64'd14025) * 64'd65536 + 64'd134512) / 64'd269025;
    sq = t * t;
    lo = 64'd0;
    hi = 64'd65535;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (pow5_shift16(mid) <= (sq << 32)) lo = mid;
      else hi = mid - 64'd1;
    end
    return 25'((sq * lo + (64'd1 << 23)) >> 24);
  endfunction

  function automatic logic [63:0] lightness_of(input fdvs_pkg::pixel_t p);
    logic [63:0] y, tgt, lo, hi, mid;
    y = (64'd13938 * lin_lut[p.red] + 64'd46868 * lin_lut[p.green]
         + 64'd4730 * lin_lut[p.blue] + 64'd32768) >> 16;
    if (y * 64'd24389 <= 64'd216 * 64'd16777216)
      return (y * 64'd24389 + 64'd27 * 64'd32768) / (64'd27 * 64'd65536);
    tgt = y << 36;
    lo = 64'd0;
    hi = 64'd1 << 20;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (mid * mid * mid <= tgt) lo = mid;
      else hi = mid - 64'd1;
    end
    return ((64'd116 * lo + 64'd2048) >> 12) - 64'd4096;
  endfunction

  // Predicts the event for one pixel and updates the shadow store.
  function automatic bit predict_event(input fdvs_pkg::pixel_t p,
                                       output fdvs_pkg::event_t ev);
    int          idx;
    logic [63:0] lvl, stamp, stored, dl;
    longint      lhs, rhs;
    bit          on, off;
    ev = '0;
    if (p.column >= fdvs_pkg::SENSOR_WIDTH || p.row >= fdvs_pkg::SENSOR_HEIGHT) return 0;
    idx   = int'(p.row) * fdvs_pkg::SENSOR_WIDTH + int'(p.column);
    lvl   = lightness_of(p);
    stamp = 64'(p.frame_number) * 64'(frame_us);
    if (stamp < 64'(quiet_mem[idx])) return 0;
    stored = 64'(level_mem[idx]);
    on  = lvl * 64'd4096 > stored * (64'd4096 + 64'(thr_q12));
    lhs = longint'(lvl * 64'd4096);
    rhs = longint'(stored) * (64'sd4096 - longint'(thr_q12));
    off = lhs < rhs;
    if (!on && !off) return 0;
    level_mem[idx] = lvl[14:0];
    dl = stamp + 64'(dead_us);
    if (dl > 64'(TIME_MAX)) dl = 64'(TIME_MAX);
    quiet_mem[idx] = dl[43:0];
    ev.event_x    = p.column;
    ev.event_y    = 8'(fdvs_pkg::SENSOR_HEIGHT - 1 - int'(p.row));
    ev.event_time = stamp[43:0];
    ev.polarity   = on;
    return 1;
  endfunction

  // Sends one pixel beat and queues its predicted event; valid stays high
  // after acceptance until a gap or the drain lowers it.
  task automatic send_pixel(input fdvs_pkg::pixel_t p, input bit has_exp, input bit fires,
                            input fdvs_pkg::event_t ev_typed);
    fdvs_pkg::event_t ev;
    bit               hit;
    hit = predict_event(p, ev);
    if (has_exp && (hit != fires || (hit && ev != ev_typed))) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row disagrees: exp %0b %h got %0b %h", fires, ev_typed, hit, ev);
    end
    if (hit) event_q = {event_q, ev};
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic input_gap();
    int n;
    if ($urandom_range(0, 2) == 0) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      fdvs_pkg::CFG_THRESHOLD:      thr_q12  = val[15:0];
      fdvs_pkg::CFG_FRAME_DURATION: frame_us = val[19:0];
      fdvs_pkg::CFG_REFRACTORY:     dead_us  = val;
      default: ;
    endcase
  endtask

  // Waits until the expected events have all arrived, then a settling pause.
  task automatic drain();
    in_valid <= 1'b0;
    while (event_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic fdvs_pkg::pixel_t rand_pixel(input bit inside_only, input int hot);
    fdvs_pkg::pixel_t p;
    if (hot > 0) begin
      p.column = 9'($urandom_range(0, 3));
      p.row    = 8'($urandom_range(0, 3));
    end else if (inside_only) begin
      p.column = 9'($urandom_range(0, fdvs_pkg::SENSOR_WIDTH - 1));
      p.row    = 8'($urandom_range(0, fdvs_pkg::SENSOR_HEIGHT - 1));
    end else begin
      p.column = 9'($urandom);
      p.row    = 8'($urandom);
    end
    p.frame_number = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    return p;
  endfunction

  // Receiver: random stalls, mostly short and now and then long, and a
  // comparison of each beat with the oldest expected event.
  always @(posedge clk) begin
    fdvs_pkg::event_t exp_ev;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected event %h", out_event);
        end else begin
          exp_ev = event_q.pop_front();
          if (out_event.event_x != exp_ev.event_x || out_event.event_y != exp_ev.event_y ||
              out_event.event_time != exp_ev.event_time ||
              out_event.polarity != exp_ev.polarity) begin
            mismatches++;
            if (mismatches <= 10)
              $display("event mismatch: exp %h got %h", exp_ev, out_event);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        stall_left = $urandom_range(10, 60);
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 29) == 0) out_ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_ready <= ~out_ready;
      else if (!out_ready && $urandom_range(0, 2) == 0) out_ready <= 1'b1;
    end
  end

  // Watchdog over cycles without any accepted beat, the clearing pass included.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && event_q.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1;
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t         r;
    fdvs_pkg::event_t none;
    int               n;
    none = '0;
    for (int i = 0; i < 256; i++) lin_lut[i] = srgb_to_linear(i);
    for (int i = 0; i < fdvs_pkg::PIXELS; i++) begin
      level_mem[i] = '0;
      quiet_mem[i] = '0;
    end
    thr_q12 = 16'd410;
    frame_us = 20'd1000;
    dead_us = 24'd1000;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: white at origin fires ON at time 0, black pixel stays quiet,
    // off-sensor pixels are ignored, corners, refractory and darkening.
    r.has_exp = 1; r.fires = 1;
    r.pix = '{9'd0, 8'd0, 24'd0, 8'd255, 8'd255, 8'd255};
    r.ev = '{9'd0, 8'd239, 44'd0, 1'b1}; dir_rows = {dir_rows, r};
    r.pix = '{9'd303, 8'd239, 24'd5, 8'd255, 8'd255, 8'd255};
    r.ev = '{9'd303, 8'd0, 44'd5000, 1'b1}; dir_rows = {dir_rows, r};
    r.fires = 0; r.ev = none;
    r.pix = '{9'd5, 8'd5, 24'd0, 8'd0, 8'd0, 8'd0}; dir_rows = {dir_rows, r};
    r.pix = '{9'd304, 8'd0, 24'd0, 8'd255, 8'd255, 8'd255}; dir_rows = {dir_rows, r};
    r.pix = '{9'd511, 8'd255, 24'hFFFFFF, 8'd255, 8'd0, 8'd0}; dir_rows = {dir_rows, r};
    r.pix = '{9'd0, 8'd240, 24'd0, 8'd9, 8'd9, 8'd9}; dir_rows = {dir_rows, r};
    // Still inside the dead time of the first event.
    r.pix = '{9'd0, 8'd0, 24'd0, 8'd0, 8'd0, 8'd0}; dir_rows = {dir_rows, r};
    r.has_exp = 0;
    r.pix = '{9'd0, 8'd0, 24'd1, 8'd0, 8'd0, 8'd0}; dir_rows = {dir_rows, r};
    r.pix = '{9'd0, 8'd0, 24'd2, 8'd10, 8'd11, 8'd12}; dir_rows = {dir_rows, r};
    r.pix = '{9'd1, 8'd0, 24'd3, 8'd1, 8'd0, 8'd0}; dir_rows = {dir_rows, r};
    r.pix = '{9'd2, 8'd0, 24'd3, 8'd0, 8'd0, 8'd1}; dir_rows = {dir_rows, r};
    r.pix = '{9'd3, 8'd0, 24'd3, 8'd128, 8'd200, 8'd50}; dir_rows = {dir_rows, r};
    r.pix = '{9'd3, 8'd0, 24'd9, 8'd120, 8'd190, 8'd45}; dir_rows = {dir_rows, r};
    r.pix = '{9'd170, 8'd85, 24'haaaaaa, 8'haa, 8'h55, 8'haa}; dir_rows = {dir_rows, r};
    r.pix = '{9'd85, 8'd170, 24'h555555, 8'h55, 8'haa, 8'h55}; dir_rows = {dir_rows, r};
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].pix, dir_rows[i].has_exp, dir_rows[i].fires, dir_rows[i].ev);
      input_gap();
    end
    drain();

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(fdvs_pkg::CFG_THRESHOLD, 24'd0);
                 write_reg(fdvs_pkg::CFG_FRAME_DURATION, 24'd0);
                 write_reg(fdvs_pkg::CFG_REFRACTORY, 24'd0); end
        1: begin write_reg(fdvs_pkg::CFG_THRESHOLD, 24'hFFFF);
                 write_reg(fdvs_pkg::CFG_FRAME_DURATION, 24'hFFFFF);
                 write_reg(fdvs_pkg::CFG_REFRACTORY, 24'hFFFFFF); end
        2: begin write_reg(fdvs_pkg::CFG_THRESHOLD, 24'd1);
                 write_reg(fdvs_pkg::CFG_FRAME_DURATION, 24'd1);
                 write_reg(fdvs_pkg::CFG_REFRACTORY, 24'd2); end
        3: begin write_reg(fdvs_pkg::CFG_THRESHOLD, 24'd4096);
                 write_reg(fdvs_pkg::CFG_FRAME_DURATION, 24'd1000000);
                 write_reg(fdvs_pkg::CFG_REFRACTORY, 24'd500); end
        4: begin write_reg(fdvs_pkg::CFG_THRESHOLD, 24'hFFFFFF);
                 write_reg(fdvs_pkg::CFG_FRAME_DURATION, 24'hFFFFFF);
                 write_reg(fdvs_pkg::CFG_REFRACTORY, 24'd0); end
        default: begin write_reg(fdvs_pkg::CFG_THRESHOLD, 24'($urandom_range(1, 3000)));
                 write_reg(fdvs_pkg::CFG_FRAME_DURATION, 24'($urandom_range(1, 40000)));
                 write_reg(fdvs_pkg::CFG_REFRACTORY, 24'($urandom_range(0, 20000))); end
      endcase
      n = 0;
      while (n < 200) begin
        fdvs_pkg::pixel_t p;
        p = rand_pixel($urandom_range(0, 9) != 0, $urandom_range(0, 2) == 0 ? 1 : 0);
        send_pixel(p, 0, 0, none);
        if (p.column < fdvs_pkg::SENSOR_WIDTH && p.row < fdvs_pkg::SENSOR_HEIGHT) n++;
        input_gap();
      end
      drain();
    end

    if (mismatches == 0 && event_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
